### sv/chol_pkg.sv
// shared types, constants and helpers of the cholesky factorization block
// no dependencies; used by chol_sqrt, chol_div and cholesky_factorization by scoped names

package chol_pkg;

    localparam int DATA_W        = 32;
    localparam int DIM_W         = 4;
    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_ACC,
        ST_LD_ELEM,
        ST_PIVOT,
        ST_EVAL,
        ST_SQRT,
        ST_DIV,
        ST_NEXT,
        ST_OUT
    } t_state;

    // clamp a 64-bit signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

### sv/chol_sqrt.sv
// bit-serial integer square root, two radicand bits per cycle
// depends on chol_pkg

module chol_sqrt #(
    parameter int FRAC_BITS = chol_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [chol_pkg::DATA_W-1:0]       i_radicand,
    output logic                              o_done,
    output logic [chol_pkg::DATA_W-1:0]       o_root
);
    localparam int NI = (chol_pkg::DATA_W + FRAC_BITS + 1) / 2;
    localparam int XW = 2 * NI;
    localparam int NW = $clog2(NI + 1);

    logic [XW-1:0] r_x;
    logic [NI+1:0] r_rem;
    logic [NI-1:0] r_root;
    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [NI+1:0] rem_sh;
    logic [NI+1:0] trial;

    assign rem_sh = {r_rem[NI-1:0], r_x[XW-1 -: 2]};
    assign trial  = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= XW'({i_radicand, {FRAC_BITS{1'b0}}});
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_x <= {r_x[XW-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[NI-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[NI-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == NW'(NI - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = chol_pkg::DATA_W'(r_root);

endmodule

### sv/chol_div.sv
// restoring divider, one quotient bit per cycle, signed result saturated
// depends on chol_pkg

module chol_div #(
    parameter int FRAC_BITS = chol_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [chol_pkg::DATA_W-1:0]  i_num,
    input  logic [chol_pkg::DATA_W-1:0]         i_den,
    output logic                                o_done,
    output logic signed [chol_pkg::DATA_W-1:0]  o_quot
);
    localparam int DW = chol_pkg::DATA_W + FRAC_BITS;
    localparam int NW = $clog2(DW + 1);
    localparam int W  = chol_pkg::DATA_W;

    logic [DW-1:0] r_dvd;
    logic [DW-1:0] r_q;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_den;
    logic          r_neg;
    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W:0]    rem_sh;
    logic [W-1:0]  num_mag;

    assign num_mag = i_num[W-1] ? (~i_num + 1'b1) : i_num;
    assign rem_sh  = {r_rem[W-1:0], r_dvd[DW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= {num_mag, {FRAC_BITS{1'b0}}};
                r_neg  <= i_num[W-1];
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[DW-2:0], 1'b0};
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem <= rem_sh - {1'b0, r_den};
                    r_q   <= {r_q[DW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_q   <= {r_q[DW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == NW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // truncation toward zero, then clamp
    always_comb begin
        if (r_neg) begin
            if (r_q > DW'(64'h80000000)) begin
                o_quot = 32'sh80000000;
            end else begin
                o_quot = W'(~r_q + 1'b1);
            end
        end else begin
            if (r_q > DW'(64'h7fffffff)) begin
                o_quot = 32'sh7fffffff;
            end else begin
                o_quot = W'(r_q);
            end
        end
    end

    assign o_done = r_done;

endmodule

### sv/cholesky_factorization.sv
// cholesky factorization top level: load sequencer, factor sequencer,
// shared multiply-accumulate, matrix memory; uses chol_pkg, chol_sqrt, chol_div
//
// channel   direction  signals                                  transaction
// input     in         start, busy, i_element                   start && !busy
// config    in         i_cfg_we, i_cfg_data                     i_cfg_we
// result    out        o_valid, o_value, o_last_of_run,         o_valid
//                      o_pivot_fault
//
// an element is taken on each accepted start; busy stays low while a matrix is loading
// after the last element each multiply-accumulate steps through RD_A, RD_B, MUL
// and ACC (one memory read port, two reads each), each square root and divide
// runs in its own unit, then the dim*dim results are output
// busy is high the whole time
// results stream one per cycle and cannot be stalled by the receiver
// reset is synchronous active low; the matrix memory has no reset

module cholesky_factorization #(
    parameter int MAX_DIM   = chol_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = chol_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [chol_pkg::DATA_W-1:0]  i_element,
    input  logic                                i_cfg_we,
    input  logic [chol_pkg::DIM_W-1:0]          i_cfg_data,
    output logic                                o_valid,
    output logic signed [chol_pkg::DATA_W-1:0]  o_value,
    output logic                                o_last_of_run,
    output logic                                o_pivot_fault
);
    localparam int W     = chol_pkg::DATA_W;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_DIM + 1);

    // row/col to memory address
    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    chol_pkg::t_state r_state, n_state;

    logic [chol_pkg::DIM_W-1:0] r_dim;
    logic [CW-1:0] d_m1;

    // load counters
    logic [CW-1:0] r_lr, r_lc;
    // factor indexes: column j, row i, dot index k
    logic [CW-1:0] r_i, r_j, r_k;
    logic [CW-1:0] r_or, r_oc;

    logic signed [W-1:0]  r_opa;
    logic signed [63:0]   r_prod;
    logic signed [63:0]   r_acc;
    logic signed [W-1:0]  r_diff;
    logic [W-1:0]         r_diag;
    logic                 r_colfault;
    logic                 r_fault;
    logic                 r_ovalid;
    logic                 r_olast;

    // memory holds A lower triangle, overwritten in place by L
    logic signed [W-1:0] mem [DEPTH];
    logic signed [W-1:0] r_rdata;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic signed [W-1:0]  mem_wdata;
    logic [AW-1:0]        mem_raddr;

    logic                 accept;
    logic                 load_done;
    logic                 sqrt_start, sqrt_done;
    logic [W-1:0]         sqrt_root;
    logic                 div_start, div_done;
    logic signed [W-1:0]  div_quot;
    logic                 diff_nonpos;
    logic                 col_last, row_last, out_last;

    // effective dimension minus one
    always_comb begin
        if (r_dim == '0) begin
            d_m1 = '0;
        end else if (int'(r_dim) > MAX_DIM) begin
            d_m1 = CW'(MAX_DIM - 1);
        end else begin
            d_m1 = CW'(r_dim) - 1'b1;
        end
    end

    assign accept      = start && !busy;
    assign load_done   = (r_lr == d_m1) && (r_lc == d_m1);
    assign diff_nonpos = r_diff[W-1] || (r_diff == '0);
    assign row_last    = (r_i == d_m1);
    assign col_last    = (r_j == d_m1);
    assign out_last    = (r_or == d_m1) && (r_oc == d_m1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            chol_pkg::ST_IDLE: begin
                if (accept && load_done) n_state = chol_pkg::ST_LD_ELEM;
            end
            chol_pkg::ST_RD_A:    n_state = chol_pkg::ST_RD_B;
            chol_pkg::ST_RD_B:    n_state = chol_pkg::ST_MUL;
            chol_pkg::ST_MUL:     n_state = chol_pkg::ST_ACC;
            chol_pkg::ST_ACC: begin
                n_state = (r_k + 1'b1 == r_j) ? chol_pkg::ST_LD_ELEM : chol_pkg::ST_RD_A;
            end
            chol_pkg::ST_LD_ELEM: n_state = chol_pkg::ST_PIVOT;
            chol_pkg::ST_PIVOT:   n_state = chol_pkg::ST_EVAL;
            chol_pkg::ST_EVAL: begin
                if (r_i == r_j) begin
                    n_state = diff_nonpos ? chol_pkg::ST_NEXT : chol_pkg::ST_SQRT;
                end else begin
                    n_state = r_colfault ? chol_pkg::ST_NEXT : chol_pkg::ST_DIV;
                end
            end
            chol_pkg::ST_SQRT: begin
                if (sqrt_done) n_state = chol_pkg::ST_NEXT;
            end
            chol_pkg::ST_DIV: begin
                if (div_done) n_state = chol_pkg::ST_NEXT;
            end
            chol_pkg::ST_NEXT: begin
                if (row_last && col_last) begin
                    n_state = chol_pkg::ST_OUT;
                end else if (!row_last && (r_j == '0)) begin
                    // first column has no dot terms
                    n_state = chol_pkg::ST_LD_ELEM;
                end else begin
                    // every later column has at least one dot term
                    n_state = chol_pkg::ST_RD_A;
                end
            end
            chol_pkg::ST_OUT: begin
                if (out_last) n_state = chol_pkg::ST_IDLE;
            end
            default: n_state = chol_pkg::ST_IDLE;
        endcase
    end

    // memory port and unit control
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = f_addr(r_i, r_j);
        mem_wdata  = '0;
        mem_raddr  = f_addr(r_i, r_j);
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        case (r_state)
            chol_pkg::ST_IDLE: begin
                mem_waddr = f_addr(r_lr, r_lc);
                mem_wdata = i_element;
                mem_we    = accept && (r_lc <= r_lr);
            end
            chol_pkg::ST_RD_A: mem_raddr = f_addr(r_i, r_k);
            chol_pkg::ST_RD_B: mem_raddr = f_addr(r_j, r_k);
            chol_pkg::ST_EVAL: begin
                if (r_i == r_j) begin
                    // pivot not positive: column becomes zero
                    mem_we     = diff_nonpos;
                    sqrt_start = !diff_nonpos;
                end else begin
                    mem_we    = r_colfault;
                    div_start = !r_colfault;
                end
            end
            chol_pkg::ST_SQRT: begin
                mem_we    = sqrt_done;
                mem_wdata = sqrt_root;
            end
            chol_pkg::ST_DIV: begin
                mem_we    = div_done;
                mem_wdata = div_quot;
            end
            chol_pkg::ST_OUT: begin
                // upper entries mirror the lower factor
                mem_raddr = (r_oc <= r_or) ? f_addr(r_or, r_oc) : f_addr(r_oc, r_or);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= chol_pkg::ST_IDLE;
            r_dim      <= chol_pkg::DIM_RESET;
            r_lr       <= '0;
            r_lc       <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_or       <= '0;
            r_oc       <= '0;
            r_fault    <= 1'b0;
            r_colfault <= 1'b0;
            r_ovalid   <= 1'b0;
            r_olast    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= (r_state == chol_pkg::ST_OUT);
            r_olast  <= (r_state == chol_pkg::ST_OUT) && out_last;

            if (i_cfg_we) begin
                r_dim <= i_cfg_data;
                r_lr  <= '0;
                r_lc  <= '0;
            end else if (accept) begin
                if (r_lc == d_m1) begin
                    r_lc <= '0;
                    r_lr <= load_done ? '0 : r_lr + 1'b1;
                end else begin
                    r_lc <= r_lc + 1'b1;
                end
            end

            case (r_state)
                chol_pkg::ST_IDLE: begin
                    if (accept && load_done) begin
                        r_i        <= '0;
                        r_j        <= '0;
                        r_k        <= '0;
                        r_fault    <= 1'b0;
                        r_colfault <= 1'b0;
                    end
                end
                chol_pkg::ST_ACC:  r_k <= r_k + 1'b1;
                chol_pkg::ST_EVAL: begin
                    if ((r_i == r_j) && diff_nonpos) begin
                        r_fault    <= 1'b1;
                        r_colfault <= 1'b1;
                    end
                end
                chol_pkg::ST_NEXT: begin
                    r_k <= '0;
                    if (row_last) begin
                        r_j        <= r_j + 1'b1;
                        r_i        <= r_j + 1'b1;
                        r_colfault <= 1'b0;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                    r_or <= '0;
                    r_oc <= '0;
                end
                chol_pkg::ST_OUT: begin
                    if (r_oc == d_m1) begin
                        r_oc <= '0;
                        r_or <= r_or + 1'b1;
                    end else begin
                        r_oc <= r_oc + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // shared multiply-accumulate datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            chol_pkg::ST_IDLE: r_acc <= '0;
            chol_pkg::ST_RD_B: r_opa <= r_rdata;
            chol_pkg::ST_MUL:  r_prod <= r_opa * r_rdata;
            chol_pkg::ST_ACC:  r_acc <= r_acc + (r_prod >>> FRAC_BITS);
            chol_pkg::ST_PIVOT: begin
                r_diff <= chol_pkg::sat32(64'(r_rdata) - r_acc);
            end
            chol_pkg::ST_SQRT: begin
                if (sqrt_done) r_diag <= sqrt_root;
            end
            chol_pkg::ST_NEXT: r_acc <= '0;
            default: begin
            end
        endcase
    end

    chol_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_diff),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    chol_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_diff),
        .i_den   (r_diag),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // busy covers the last result cycle too
    assign busy          = (r_state != chol_pkg::ST_IDLE) || r_ovalid;
    assign o_valid       = r_ovalid;
    assign o_value       = r_rdata;
    assign o_last_of_run = r_olast;
    assign o_pivot_fault = r_fault;

endmodule

### sv/chol_checker.sv
// port-level checks of the cholesky factorization block, bound to the top
// depends on cholesky_factorization's ports only

module chol_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic busy,
    input logic o_valid,
    input logic o_last_of_run,
    input logic o_pivot_fault
);

    // results only appear while the block is busy
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside busy");

    // results of one run come back to back
    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |=> o_valid) else $error("gap in result stream");

    // fault flag is constant over a run
    a_fault_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |=> $stable(o_pivot_fault))
        else $error("fault flag changed mid run");

    // busy drops only right after the final result
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> $past(o_valid) && $past(o_last_of_run))
        else $error("busy fell without final result");

endmodule

bind cholesky_factorization chol_checker u_chol_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_last_of_run (o_last_of_run),
    .o_pivot_fault (o_pivot_fault)
);
